[sv/pid_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pid_pkg
// Shared types, register map and Q16.16 arithmetic for the PID controller.
// ----------------------------------------------------------------------------
package pid_pkg;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned ADDR_W = 5;

  typedef logic signed [DATA_W-1:0] q16_t;

  // register indexes (byte address is 4 * index)
  typedef enum logic [2:0] {
    REG_PROP_GAIN  = 3'd0,
    REG_INTEG_GAIN = 3'd1,
    REG_DERIV_GAIN = 3'd2,
    REG_OUT_LOWER  = 3'd3,
    REG_OUT_UPPER  = 3'd4
  } reg_idx_t;

  typedef enum logic {
    REQ_COMPUTE = 1'b0,
    REQ_RESET   = 1'b1
  } req_t;

  localparam q16_t LOWER_RESET = 32'sh8000_0000;
  localparam q16_t UPPER_RESET = 32'sh7FFF_FFFF;

  // full signed product, arithmetic shift by 16, keep low 32 bits
  function automatic q16_t fx_mul(input q16_t a, input q16_t b);
    logic signed [2*DATA_W-1:0] prod;
    prod = 64'(a) * 64'(b);
    return prod[DATA_W+15:16];
  endfunction

  // lower limit wins when x <= lo, even with inverted limits
  function automatic q16_t fx_clamp(input q16_t x, input q16_t lo, input q16_t hi);
    q16_t res;
    if (x > lo) begin
      res = (x < hi) ? x : hi;
    end else begin
      res = lo;
    end
    return res;
  endfunction

endpackage

[sv/pid_in_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pid_in_if
// Request channel: request type, measurement, setpoint and preload value.
// ----------------------------------------------------------------------------
interface pid_in_if
  import pid_pkg::*;
();
  logic valid;
  logic ready;
  req_t req_type;
  q16_t measured;
  q16_t setpoint;
  q16_t preload_output;

  modport source (output valid, output req_type, output measured,
                  output setpoint, output preload_output, input ready);
  modport sink   (input valid, input req_type, input measured,
                  input setpoint, input preload_output, output ready);
endinterface

[sv/pid_out_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pid_out_if
// Result channel: clamped control drive.
// ----------------------------------------------------------------------------
interface pid_out_if
  import pid_pkg::*;
();
  logic valid;
  logic ready;
  q16_t drive;

  modport source (output valid, output drive, input ready);
  modport sink   (input valid, input drive, output ready);
endinterface

[sv/fixed_point_pid_controller.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fixed_point_pid_controller
// Q16.16 PID step with derivative on measurement and a clamped integrator.
// ----------------------------------------------------------------------------
// A word accepted on the request channel passes the input, product, integrator
//   and output registers in turn before it appears on the result channel.
// Throughput: one word per cycle while the result channel is ready; the integrator
//   add and clamp are combinational, so back-to-back words need no bubbles.
// An empty stage fills while a result waits, so words keep entering until every stage is full.
// Reset (rst, synchronous): pipeline emptied, integrator and last measurement
//   zeroed, gains zeroed, limits set to the full signed range.
module fixed_point_pid_controller
  import pid_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  pid_in_if.sink            in_ch,
  pid_out_if.source         out_ch
);

  q16_t prop_gain, integ_gain, deriv_gain, out_lower, out_upper;
  q16_t integ_acc, last_measured;

  // stage valid bits and load enables
  logic v1, v2, v3, vo;
  logic ld1, ld2, ld3, ld_o;

  // stage payloads
  req_t s1_req, s2_req, s3_req;
  q16_t s1_err, s1_dmeas, s1_pre;
  q16_t s2_p, s2_i, s2_d, s2_pre;
  q16_t s3_integ, s3_pd;
  q16_t drive;

  q16_t integ_next, drive_next;
  logic cfg_wr;
  reg_idx_t cfg_idx;

  assign pready  = 1'b1;
  assign cfg_idx = reg_idx_t'(paddr[ADDR_W-1:2]);
  assign cfg_wr  = psel && penable && pwrite;

  always_comb begin
    case (cfg_idx)
      REG_PROP_GAIN:  prdata = prop_gain;
      REG_INTEG_GAIN: prdata = integ_gain;
      REG_DERIV_GAIN: prdata = deriv_gain;
      REG_OUT_LOWER:  prdata = out_lower;
      REG_OUT_UPPER:  prdata = out_upper;
      default:        prdata = '0;
    endcase
  end

  assign ld_o = !vo || out_ch.ready;
  assign ld3  = !v3 || ld_o;
  assign ld2  = !v2 || ld3;
  assign ld1  = !v1 || ld2;

  assign in_ch.ready  = ld1;
  assign out_ch.valid = vo;
  assign out_ch.drive = drive;

  always_comb begin
    if (s2_req == REQ_RESET) begin
      integ_next = fx_clamp(s2_pre, out_lower, out_upper);
    end else begin
      integ_next = fx_clamp(integ_acc + s2_i, out_lower, out_upper);
    end
  end

  always_comb begin
    if (s3_req == REQ_RESET) begin
      drive_next = s3_integ;
    end else begin
      drive_next = fx_clamp(s3_pd + s3_integ, out_lower, out_upper);
    end
  end

  // control, configuration and loop state
  always_ff @(posedge clk) begin
    if (rst) begin
      v1            <= 1'b0;
      v2            <= 1'b0;
      v3            <= 1'b0;
      vo            <= 1'b0;
      prop_gain     <= '0;
      integ_gain    <= '0;
      deriv_gain    <= '0;
      out_lower     <= LOWER_RESET;
      out_upper     <= UPPER_RESET;
      integ_acc     <= '0;
      last_measured <= '0;
    end else begin
      if (ld1) v1 <= in_ch.valid;
      if (ld2) v2 <= v1;
      if (ld3) v3 <= v2;
      if (ld_o) vo <= v3;
      // every request, reset or compute, becomes the new last measurement
      if (ld1 && in_ch.valid) last_measured <= in_ch.measured;
      if (ld3 && v2) integ_acc <= integ_next;
      if (cfg_wr) begin
        case (cfg_idx)
          REG_PROP_GAIN:  prop_gain  <= pwdata;
          REG_INTEG_GAIN: integ_gain <= pwdata;
          REG_DERIV_GAIN: deriv_gain <= pwdata;
          REG_OUT_LOWER:  out_lower  <= pwdata;
          REG_OUT_UPPER:  out_upper  <= pwdata;
          default: ;
        endcase
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (ld1 && in_ch.valid) begin
      s1_req   <= in_ch.req_type;
      s1_err   <= in_ch.measured - in_ch.setpoint;
      s1_dmeas <= in_ch.measured - last_measured;
      s1_pre   <= in_ch.preload_output;
    end
    if (ld2 && v1) begin
      s2_req <= s1_req;
      s2_p   <= fx_mul(prop_gain, s1_err);
      s2_i   <= fx_mul(integ_gain, s1_err);
      s2_d   <= fx_mul(deriv_gain, s1_dmeas);
      s2_pre <= s1_pre;
    end
    if (ld3 && v2) begin
      s3_req   <= s2_req;
      s3_integ <= integ_next;
      s3_pd    <= s2_p + s2_d;
    end
    if (ld_o && v3) begin
      drive <= drive_next;
    end
  end

  // integrator lands inside ordered limits after every update
  a_integ_in_range: assert property (@(posedge clk) disable iff (rst)
    (ld3 && v2 && (out_lower <= out_upper)) |=>
      ((integ_acc >= $past(out_lower)) && (integ_acc <= $past(out_upper))))
    else $error("integrator outside limits");

  // integrator moves only when a word passes the integrator stage
  a_integ_hold: assert property (@(posedge clk) disable iff (rst)
    !(ld3 && v2) |=> $stable(integ_acc))
    else $error("integrator changed without a word");

  // a new result comes only from a full integrator stage
  a_out_source: assert property (@(posedge clk) disable iff (rst)
    $rose(vo) |-> $past(v3))
    else $error("result without source word");

  // an empty pipeline always takes a word
  a_ready_empty: assert property (@(posedge clk) disable iff (rst)
    (!v1 && !v2 && !v3 && !vo) |-> in_ch.ready)
    else $error("empty pipeline not ready");

endmodule
